>>> hdl/mtr_pkg.sv
// ----------------------------------------------------------------------------
// Media timestamp repair package
// Shared constants, register codes, state types and helpers.
// ----------------------------------------------------------------------------
package mtr_pkg;

	localparam int REG_W      = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int SCALE_W    = 2 * REG_W;
	localparam int DIGIT_W    = 8;
	localparam int NUM_DIGITS = SCALE_W / DIGIT_W;

	localparam int JUMP_LIMIT = 90000;
	localparam int GAP_LIMIT  = 90000 * 10;
	localparam int GAP_CAP    = 90000 * 5;

	localparam logic [REG_W-1:0] IN_NUM_RST  = REG_W'(1);
	localparam logic [REG_W-1:0] IN_DEN_RST  = REG_W'(90000);
	localparam logic [REG_W-1:0] OUT_NUM_RST = REG_W'(1);
	localparam logic [REG_W-1:0] OUT_DEN_RST = REG_W'(90000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_NUM,
		CFG_IN_DEN,
		CFG_OUT_NUM,
		CFG_OUT_DEN
	} cfg_idx_t;

	typedef struct packed {
		logic back;
		logic jump;
	} rep_flags_t;

	typedef enum logic [2:0] {
		R_IDLE,
		R_FILL,
		R_POSP,
		R_POSD,
		R_CMP,
		R_FIX,
		R_DONE
	} rep_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_RND,
		S_CHK,
		S_DIV,
		S_DONE
	} scl_state_t;

	typedef enum logic [3:0] {
		T_IDLE,
		T_REP,
		T_SP,
		T_WP,
		T_SD,
		T_WD,
		T_CLAMP,
		T_GAP,
		T_OUT
	} top_state_t;

	function automatic logic [REG_W-1:0] nz_reg(input logic [REG_W-1:0] r);
		return (r == '0) ? REG_W'(1) : r;
	endfunction

endpackage

>>> hdl/mtr_repair.sv
// ----------------------------------------------------------------------------
// Timestamp repair sequencer
// Tracks the last decode time and fills, fixes and flags one timestamp pair.
// ----------------------------------------------------------------------------
module mtr_repair #(
	parameter int TS_WIDTH = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      restart,
	input  logic                      pres_valid,
	input  logic [TS_WIDTH-1:0]       pres_time,
	input  logic                      dec_valid,
	input  logic [TS_WIDTH-1:0]       dec_time,
	output logic                      done,
	output logic [TS_WIDTH-1:0]       pres_fix,
	output logic [TS_WIDTH-1:0]       dec_fix,
	output mtr_pkg::rep_flags_t       flags
);

	localparam logic signed [TS_WIDTH-1:0] TS_MAX = {1'b0, {(TS_WIDTH-1){1'b1}}};
	localparam logic signed [TS_WIDTH-1:0] TS_MIN = {1'b1, {(TS_WIDTH-1){1'b0}}};
	localparam logic signed [TS_WIDTH-1:0] ONE    = TS_WIDTH'(1);
	localparam logic signed [TS_WIDTH-1:0] JUMP   = TS_WIDTH'(mtr_pkg::JUMP_LIMIT);

	mtr_pkg::rep_state_t state_q, state_d;
	logic                       pv_q, dv_q, known_q, ready_q, lt_q;
	logic signed [TS_WIDTH-1:0] pres_q, dec_q, last_q, fix_q, lim_q, diff_q;
	logic signed [TS_WIDTH-1:0] inc_v;
	mtr_pkg::rep_flags_t        flags_q;

	function automatic logic signed [TS_WIDTH-1:0] sat_add(
		input logic signed [TS_WIDTH-1:0] a,
		input logic signed [TS_WIDTH-1:0] b
	);
		logic [TS_WIDTH:0] s;
		s = {a[TS_WIDTH-1], a} + {b[TS_WIDTH-1], b};
		if (s[TS_WIDTH] != s[TS_WIDTH-1]) begin
			return s[TS_WIDTH] ? TS_MIN : TS_MAX;
		end
		return s[TS_WIDTH-1:0];
	endfunction

	function automatic logic is_pos(input logic signed [TS_WIDTH-1:0] v);
		return !v[TS_WIDTH-1] && (|v);
	endfunction

	assign inc_v = sat_add(last_q, ONE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mtr_pkg::R_IDLE: if (start) state_d = mtr_pkg::R_FILL;
			mtr_pkg::R_FILL: state_d = mtr_pkg::R_POSP;
			mtr_pkg::R_POSP: state_d = mtr_pkg::R_POSD;
			mtr_pkg::R_POSD: state_d = mtr_pkg::R_CMP;
			mtr_pkg::R_CMP:  state_d = mtr_pkg::R_FIX;
			mtr_pkg::R_FIX:  state_d = mtr_pkg::R_DONE;
			mtr_pkg::R_DONE: state_d = mtr_pkg::R_IDLE;
			default:         state_d = mtr_pkg::R_IDLE;
		endcase
	end

	always_comb begin
		done     = (state_q == mtr_pkg::R_DONE);
		pres_fix = pres_q;
		dec_fix  = dec_q;
		flags    = flags_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtr_pkg::R_IDLE;
			ready_q <= 1'b0;
			known_q <= 1'b0;
			last_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mtr_pkg::R_IDLE && start && (restart || !ready_q)) begin
				ready_q <= 1'b1;
				if (dec_valid) begin
					last_q  <= dec_time;
					known_q <= 1'b1;
				end else if (pres_valid) begin
					last_q  <= pres_time;
					known_q <= 1'b1;
				end else begin
					last_q  <= '0;
					known_q <= 1'b0;
				end
			end
			if (state_q == mtr_pkg::R_FIX) begin
				last_q  <= (known_q && lt_q) ? fix_q : dec_q;
				known_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mtr_pkg::R_IDLE: begin
				if (start) begin
					pv_q    <= pres_valid;
					dv_q    <= dec_valid;
					pres_q  <= pres_time;
					dec_q   <= dec_time;
					flags_q <= '0;
				end
			end
			mtr_pkg::R_FILL: begin
				if (!pv_q && !dv_q) begin
					pres_q <= known_q ? inc_v : ONE;
					dec_q  <= known_q ? inc_v : ONE;
				end else if (!pv_q) begin
					pres_q <= dec_q;
				end else if (!dv_q) begin
					dec_q <= pres_q;
				end
			end
			mtr_pkg::R_POSP: begin
				if (!is_pos(pres_q)) pres_q <= is_pos(dec_q) ? dec_q : ONE;
			end
			mtr_pkg::R_POSD: begin
				if (!is_pos(dec_q)) dec_q <= is_pos(pres_q) ? pres_q : ONE;
			end
			mtr_pkg::R_CMP: begin
				lt_q   <= dec_q < last_q;
				fix_q  <= inc_v;
				lim_q  <= sat_add(last_q, JUMP);
				diff_q <= pres_q - dec_q;
			end
			mtr_pkg::R_FIX: begin
				if (known_q && lt_q) begin
					dec_q        <= fix_q;
					pres_q       <= sat_add(fix_q, diff_q);
					flags_q.back <= 1'b1;
				end else if (known_q && (dec_q > lim_q)) begin
					flags_q.jump <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/mtr_rescale.sv
// ----------------------------------------------------------------------------
// Digit-serial rescale unit
// Computes round(x * b / c) for a positive x: byte-serial multiply, then
// bit-serial restoring division, saturating to the positive timestamp range.
// ----------------------------------------------------------------------------
module mtr_rescale #(
	parameter int TS_WIDTH = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [TS_WIDTH-2:0]           x,
	input  logic [mtr_pkg::SCALE_W-1:0]   b,
	input  logic [mtr_pkg::SCALE_W-1:0]   c,
	output logic                          done,
	output logic [TS_WIDTH-2:0]           y
);

	localparam int MAG_W = TS_WIDTH - 1;
	localparam int DW    = TS_WIDTH + mtr_pkg::SCALE_W;
	localparam int PW    = MAG_W + mtr_pkg::DIGIT_W;
	localparam int HW    = DW - MAG_W;
	localparam int SW    = mtr_pkg::SCALE_W;
	localparam int CW    = $clog2(TS_WIDTH);

	mtr_pkg::scl_state_t state_q, state_d;
	logic [CW-1:0]     cnt_q;
	logic [MAG_W-1:0]  a_q, sh_q;
	logic [SW-1:0]     b_q, c_q, rem_q;
	logic [DW-1:0]     acc_q;
	logic              sat_q;
	logic [PW-1:0]     prod;
	logic              over;
	logic [SW:0]       trial;
	logic              ge;
	logic              mul_last, div_last;

	assign prod     = PW'(a_q) * PW'(b_q[SW-1 -: mtr_pkg::DIGIT_W]);
	assign over     = acc_q[DW-1:MAG_W] >= HW'(c_q);
	assign trial    = {rem_q, sh_q[MAG_W-1]};
	assign ge       = trial >= {1'b0, c_q};
	assign mul_last = (cnt_q == CW'(mtr_pkg::NUM_DIGITS - 1));
	assign div_last = (cnt_q == CW'(MAG_W - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			mtr_pkg::S_IDLE: if (start) state_d = mtr_pkg::S_MUL;
			mtr_pkg::S_MUL:  if (mul_last) state_d = mtr_pkg::S_RND;
			mtr_pkg::S_RND:  state_d = mtr_pkg::S_CHK;
			mtr_pkg::S_CHK:  state_d = over ? mtr_pkg::S_DONE : mtr_pkg::S_DIV;
			mtr_pkg::S_DIV:  if (div_last) state_d = mtr_pkg::S_DONE;
			mtr_pkg::S_DONE: state_d = mtr_pkg::S_IDLE;
			default:         state_d = mtr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == mtr_pkg::S_DONE);
		y    = sat_q ? {MAG_W{1'b1}} : sh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtr_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mtr_pkg::S_MUL || state_q == mtr_pkg::S_DIV) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mtr_pkg::S_IDLE: begin
				if (start) begin
					a_q   <= x;
					b_q   <= b;
					c_q   <= c;
					acc_q <= '0;
					sat_q <= 1'b0;
				end
			end
			mtr_pkg::S_MUL: begin
				acc_q <= (acc_q << mtr_pkg::DIGIT_W) + DW'(prod);
				b_q   <= b_q << mtr_pkg::DIGIT_W;
			end
			mtr_pkg::S_RND: begin
				acc_q <= acc_q + DW'(c_q >> 1);
			end
			mtr_pkg::S_CHK: begin
				sat_q <= over;
				rem_q <= acc_q[MAG_W +: SW];
				sh_q  <= acc_q[MAG_W-1:0];
			end
			mtr_pkg::S_DIV: begin
				rem_q <= ge ? SW'(trial - {1'b0, c_q}) : trial[SW-1:0];
				sh_q  <= {sh_q[MAG_W-2:0], ge};
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/media_timestamp_repair_core.sv
// Results come from the shared rescale unit, run once per timestamp: byte-serial multiply,
// then one quotient bit per cycle; a saturating rescale skips the division.
// One item is in work at a time; the next is accepted in the cycle after the result loads
// the output register, which happens only once the output is not stalled.
// Reset (async, active low) clears tracker, sequencers, output valid; time base = 1/90000.
// ----------------------------------------------------------------------------
// Media timestamp repair core
// Repairs a presentation/decode timestamp pair, rescales both to the output
// time base and enforces presentation >= decode with a capped gap.
// ----------------------------------------------------------------------------
module media_timestamp_repair_core #(
	parameter int TS_WIDTH = 48
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mtr_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  logic [mtr_pkg::REG_W-1:0]              cfg_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// restart, pres_valid, pres_time, dec_valid, dec_time, zero pad
	input  logic [((2*TS_WIDTH+3+7)/8)*8-1:0]      s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// pres_out, dec_out, backward_fixed, large_jump, zero pad
	output logic [((2*TS_WIDTH+2+7)/8)*8-1:0]      m_tdata
);

	localparam int OUT_TW = ((2*TS_WIDTH+2+7)/8)*8;
	localparam int MAG_W  = TS_WIDTH - 1;

	mtr_pkg::top_state_t state_q, state_d;
	logic [mtr_pkg::REG_W-1:0]   in_num_q, in_den_q, out_num_q, out_den_q;
	logic [mtr_pkg::SCALE_W-1:0] b_q, c_q;
	logic [MAG_W-1:0]            po_q, dq_q, cap_q, po_fin;
	logic                        over_q;
	logic [TS_WIDTH-1:0]         cap_sum;
	logic                        m_tvalid_q;
	logic [OUT_TW-1:0]           m_tdata_q;

	logic                        accept, out_load, sc_start, sc_use_dec;
	logic                        rep_done, sc_done;
	logic [TS_WIDTH-1:0]         pres_fix, dec_fix;
	logic [MAG_W-1:0]            sc_x, sc_y;
	mtr_pkg::rep_flags_t         flags;

	assign accept = s_tvalid && s_tready;

	mtr_repair #(.TS_WIDTH(TS_WIDTH)) u_repair (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.restart    (s_tdata[0]),
		.pres_valid (s_tdata[1]),
		.pres_time  (s_tdata[TS_WIDTH+1:2]),
		.dec_valid  (s_tdata[TS_WIDTH+2]),
		.dec_time   (s_tdata[2*TS_WIDTH+2:TS_WIDTH+3]),
		.done       (rep_done),
		.pres_fix   (pres_fix),
		.dec_fix    (dec_fix),
		.flags      (flags)
	);

	assign sc_x = sc_use_dec ? dec_fix[MAG_W-1:0] : pres_fix[MAG_W-1:0];

	mtr_rescale #(.TS_WIDTH(TS_WIDTH)) u_rescale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.x      (sc_x),
		.b      (b_q),
		.c      (c_q),
		.done   (sc_done),
		.y      (sc_y)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mtr_pkg::T_IDLE:  if (s_tvalid) state_d = mtr_pkg::T_REP;
			mtr_pkg::T_REP:   if (rep_done) state_d = mtr_pkg::T_SP;
			mtr_pkg::T_SP:    state_d = mtr_pkg::T_WP;
			mtr_pkg::T_WP:    if (sc_done) state_d = mtr_pkg::T_SD;
			mtr_pkg::T_SD:    state_d = mtr_pkg::T_WD;
			mtr_pkg::T_WD:    if (sc_done) state_d = mtr_pkg::T_CLAMP;
			mtr_pkg::T_CLAMP: state_d = mtr_pkg::T_GAP;
			mtr_pkg::T_GAP:   state_d = mtr_pkg::T_OUT;
			mtr_pkg::T_OUT:   if (!m_tvalid_q || m_tready) state_d = mtr_pkg::T_IDLE;
			default:          state_d = mtr_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == mtr_pkg::T_IDLE);
		sc_start   = (state_q == mtr_pkg::T_SP) || (state_q == mtr_pkg::T_SD);
		sc_use_dec = (state_q == mtr_pkg::T_SD);
		out_load   = (state_q == mtr_pkg::T_OUT) && (!m_tvalid_q || m_tready);
	end

	assign cap_sum = {1'b0, dq_q} + TS_WIDTH'(mtr_pkg::GAP_CAP);
	assign po_fin  = over_q ? cap_q : po_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mtr_pkg::T_IDLE;
			m_tvalid_q <= 1'b0;
			in_num_q   <= mtr_pkg::IN_NUM_RST;
			in_den_q   <= mtr_pkg::IN_DEN_RST;
			out_num_q  <= mtr_pkg::OUT_NUM_RST;
			out_den_q  <= mtr_pkg::OUT_DEN_RST;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (mtr_pkg::cfg_idx_t'(cfg_idx))
					mtr_pkg::CFG_IN_NUM:  in_num_q  <= cfg_data;
					mtr_pkg::CFG_IN_DEN:  in_den_q  <= cfg_data;
					mtr_pkg::CFG_OUT_NUM: out_num_q <= cfg_data;
					mtr_pkg::CFG_OUT_DEN: out_den_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b_q <= mtr_pkg::SCALE_W'(mtr_pkg::nz_reg(in_num_q)) *
				mtr_pkg::SCALE_W'(mtr_pkg::nz_reg(out_den_q));
			c_q <= mtr_pkg::SCALE_W'(mtr_pkg::nz_reg(in_den_q)) *
				mtr_pkg::SCALE_W'(mtr_pkg::nz_reg(out_num_q));
		end
		if (state_q == mtr_pkg::T_WP && sc_done) po_q <= sc_y;
		if (state_q == mtr_pkg::T_WD && sc_done) dq_q <= sc_y;
		if (state_q == mtr_pkg::T_CLAMP && po_q < dq_q) po_q <= dq_q;
		if (state_q == mtr_pkg::T_GAP) begin
			over_q <= (po_q - dq_q) > MAG_W'(mtr_pkg::GAP_LIMIT);
			cap_q  <= cap_sum[MAG_W] ? {MAG_W{1'b1}} : cap_sum[MAG_W-1:0];
		end
		if (out_load) begin
			m_tdata_q <= OUT_TW'({flags.jump, flags.back, 1'b0, dq_q, 1'b0, po_fin});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction accepted while one is in work");

	a_pres_not_below_dec: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[TS_WIDTH-1:0] >= m_tdata[2*TS_WIDTH-1:TS_WIDTH]))
		else $error("presentation output below decode output");

	a_rescale_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sc_done |-> (state_q == mtr_pkg::T_WP || state_q == mtr_pkg::T_WD))
		else $error("rescale finished outside a wait state");

	a_repair_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		rep_done |-> (state_q == mtr_pkg::T_REP))
		else $error("repair finished outside the repair wait state");
`endif

endmodule
